[rtl/bpc_pkg.sv]
// Package for the barometric compensation block: codes, constants, types and helpers.
package bpc_pkg;

    // Datapath and configuration port sizes
    localparam int DATA_W     = 32;
    localparam int RAW_W      = 16;
    localparam int CAL_W      = 16;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int OSS_W      = 2;
    localparam int SHIFT_W    = $clog2(DATA_W);
    localparam int DIV_CNT_W  = $clog2(DATA_W);

    // Compensation constants
    localparam logic [DATA_W-1:0] C_B6_OFS   = 32'd4000;
    localparam logic [DATA_W-1:0] C_P_SQ_K   = 32'd3038;
    localparam logic [DATA_W-1:0] C_P_LIN_K  = -32'sd7357;
    localparam logic [DATA_W-1:0] C_P_OFS    = 32'd3791;
    localparam logic [DATA_W-1:0] C_B4_OFS   = 32'd32768;
    localparam logic [DATA_W-1:0] C_B7_SCALE = 32'd50000;
    localparam logic [DATA_W-1:0] C_B7_HALF  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] C_T_ROUND  = 32'd8;
    localparam logic [DATA_W-1:0] C_B3_ROUND = 32'd2;
    localparam logic [DATA_W-1:0] C_B3_TRUNC = 32'd3;
    localparam logic [DATA_W-1:0] C_X3_ROUND = 32'd2;

    // Input command and result kind codes
    localparam logic CMD_TEMP = 1'b0;
    localparam logic CMD_PRES = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AC123 = 3'd0,
        CFG_AC456 = 3'd1,
        CFG_B12   = 3'd2,
        CFG_MCMD  = 3'd3,
        CFG_OSS   = 3'd4
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_T_MUL,
        S_T_DEN,
        S_T_CHK,
        S_DIV,
        S_T_B5,
        S_T_RES,
        S_P_B6,
        S_P_SQ,
        S_P_AC2,
        S_P_B2,
        S_P_AC3,
        S_P_B1,
        S_P_B3A,
        S_P_B3B,
        S_P_B3C,
        S_P_B3D,
        S_P_X3A,
        S_P_X3B,
        S_P_B4,
        S_P_B7A,
        S_P_B7B,
        S_P_DIV,
        S_P_SQP,
        S_P_X1,
        S_P_X2,
        S_P_SUM,
        S_P_CORR,
        S_P_FIN,
        S_OUT
    } t_state;

    // Multiplier control: post-shift amount and shift kind
    typedef struct packed {
        logic [SHIFT_W-1:0] sh;
        logic               arith;
    } t_mul_ctl;

    // Divider control
    typedef struct packed {
        logic start;
        logic is_signed;
    } t_div_ctl;

    // Arithmetic shift right of a 32-bit pattern
    function automatic logic [DATA_W-1:0] f_asr(input logic [DATA_W-1:0] v,
                                                input logic [SHIFT_W-1:0] n);
        logic signed [DATA_W-1:0] s;
        s = $signed(v);
        return DATA_W'(s >>> n);
    endfunction

endpackage

[rtl/bpc_in_if.sv]
// Input channel interface: raw reading items.
interface bpc_in_if;
    import bpc_pkg::*;

    logic             valid;
    logic             ready;
    logic             command;
    logic [RAW_W-1:0] raw_value;

    modport source (output valid, output command, output raw_value, input ready);
    modport sink   (input valid, input command, input raw_value, output ready);
endinterface

[rtl/bpc_out_if.sv]
// Output channel interface: compensated result items.
interface bpc_out_if;
    import bpc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [DATA_W-1:0] value;
    logic                     div_error;

    modport source (output valid, output kind, output value, output div_error, input ready);
    modport sink   (input valid, input kind, input value, input div_error, output ready);
endinterface

[rtl/bpc_mul.sv]
// Shared multiplier: low 32 bits of a product, shifted right, registered.
module bpc_mul
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    input  t_mul_ctl          i_ctl,
    output logic [DATA_W-1:0] o_p
);

    logic [DATA_W-1:0] s_prod;
    logic [DATA_W-1:0] r_p;

    // Keep the wrapped low word of the product
    assign s_prod = DATA_W'(i_a * i_b);

    // Shift and register the product
    always_ff @(posedge i_clk) begin
        if (i_ctl.arith) begin
            r_p <= f_asr(s_prod, i_ctl.sh);
        end else begin
            r_p <= s_prod >> i_ctl.sh;
        end
    end

    assign o_p = r_p;

endmodule

[rtl/bpc_div.sv]
// Serial restoring divider, one quotient bit per cycle, optional signed mode.
module bpc_div
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DATA_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_dsr;
    logic                 r_neg;

    logic [DATA_W:0]      s_shift;
    logic                 s_fit;
    logic [DATA_W:0]      s_trial;
    logic [DATA_W-1:0]    s_mag_a;
    logic [DATA_W-1:0]    s_mag_d;

    // Operand magnitudes in signed mode
    assign s_mag_a = (i_ctl.is_signed && i_dividend[DATA_W-1]) ? (~i_dividend + 1'b1)
                                                               : i_dividend;
    assign s_mag_d = (i_ctl.is_signed && i_divisor[DATA_W-1]) ? (~i_divisor + 1'b1)
                                                              : i_divisor;

    // Trial subtract of the shifted remainder
    assign s_shift = {r_rem, r_quo[DATA_W-1]};
    assign s_fit   = (s_shift >= {1'b0, r_dsr});
    assign s_trial = s_shift - {1'b0, r_dsr};

    // Control: run for one step per quotient bit, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load magnitudes, then shift in one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= s_mag_a;
            r_dsr <= s_mag_d;
            r_neg <= i_ctl.is_signed & (i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1]);
        end else if (r_busy) begin
            r_rem <= s_fit ? s_trial[DATA_W-1:0] : s_shift[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], s_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

[rtl/baro_pressure_temp_compensation.sv]
// Top level of the barometric compensation block: calibration registers and sequencer.
//
// Each item carries one raw reading. A temperature item runs one multiply, four adds
// and a signed 32-step serial division; a pressure item runs ten passes through the
// shared multiplier, a chain of adds and an unsigned 32-step division; an item that
// hits a zero divisor ends early, before its division starts. The block takes one
// item at a time and is ready again once the result is in the output register, which
// holds it until the sink takes it. Calibration registers reset to zero and may be
// written only while no item is in flight.
module baro_pressure_temp_compensation
    import bpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bpc_in_if.sink                i_in,
    bpc_out_if.source             o_out
);

    // Calibration registers
    logic [3*CAL_W-1:0] r_cal_ac123;
    logic [3*CAL_W-1:0] r_cal_ac456;
    logic [2*CAL_W-1:0] r_cal_b12;
    logic [2*CAL_W-1:0] r_cal_mcmd;
    logic [OSS_W-1:0]   r_oss;

    // Calibration words as 32-bit patterns
    logic [DATA_W-1:0] s_ac1, s_ac2, s_ac3, s_ac4, s_ac5, s_ac6;
    logic [DATA_W-1:0] s_b1, s_b2, s_mc, s_md;

    // Sequencer state and scratch registers
    t_state            r_state, n_state;
    logic              r_cmd, n_cmd;
    logic [RAW_W-1:0]  r_raw, n_raw;
    logic [DATA_W-1:0] r_b5, n_b5;
    logic [DATA_W-1:0] r_x1, n_x1;
    logic [DATA_W-1:0] r_x2, n_x2;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b6, n_b6;
    logic [DATA_W-1:0] r_sq, n_sq;
    logic [DATA_W-1:0] r_t, n_t;
    logic [DATA_W-1:0] r_u, n_u;
    logic [DATA_W-1:0] r_b3, n_b3;
    logic [DATA_W-1:0] r_b4, n_b4;
    logic [DATA_W-1:0] r_p, n_p;
    logic              r_big, n_big;
    logic [DATA_W-1:0] r_val, n_val;
    logic              r_err, n_err;

    // Output register
    logic              r_ovalid;
    logic              r_okind;
    logic [DATA_W-1:0] r_ovalue;
    logic              r_oerr;
    logic              s_out_load;

    // Shared adder
    logic [DATA_W-1:0] s_add_a, s_add_b, s_sum;
    logic              s_add_cin;

    // Shared multiplier and divider hookup
    logic [DATA_W-1:0] s_mul_a, s_mul_b, s_mres;
    t_mul_ctl          s_mul_ctl;
    t_div_ctl          s_div_ctl;
    logic [DATA_W-1:0] s_div_a, s_div_d, s_quot;
    logic              s_div_done;

    // Unpack calibration words
    assign s_ac1 = DATA_W'($signed(r_cal_ac123[CAL_W-1:0]));
    assign s_ac2 = DATA_W'($signed(r_cal_ac123[2*CAL_W-1:CAL_W]));
    assign s_ac3 = DATA_W'($signed(r_cal_ac123[3*CAL_W-1:2*CAL_W]));
    assign s_ac4 = {{(DATA_W-CAL_W){1'b0}}, r_cal_ac456[CAL_W-1:0]};
    assign s_ac5 = {{(DATA_W-CAL_W){1'b0}}, r_cal_ac456[2*CAL_W-1:CAL_W]};
    assign s_ac6 = {{(DATA_W-CAL_W){1'b0}}, r_cal_ac456[3*CAL_W-1:2*CAL_W]};
    assign s_b1  = DATA_W'($signed(r_cal_b12[CAL_W-1:0]));
    assign s_b2  = DATA_W'($signed(r_cal_b12[2*CAL_W-1:CAL_W]));
    assign s_mc  = DATA_W'($signed(r_cal_mcmd[CAL_W-1:0]));
    assign s_md  = DATA_W'($signed(r_cal_mcmd[2*CAL_W-1:CAL_W]));

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_ac123 <= '0;
            r_cal_ac456 <= '0;
            r_cal_b12   <= '0;
            r_cal_mcmd  <= '0;
            r_oss       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AC123: r_cal_ac123 <= i_cfg_data[3*CAL_W-1:0];
                CFG_AC456: r_cal_ac456 <= i_cfg_data[3*CAL_W-1:0];
                CFG_B12:   r_cal_b12   <= i_cfg_data[2*CAL_W-1:0];
                CFG_MCMD:  r_cal_mcmd  <= i_cfg_data[2*CAL_W-1:0];
                CFG_OSS:   r_oss       <= i_cfg_data[OSS_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_sum = s_add_a + s_add_b + {{(DATA_W-1){1'b0}}, s_add_cin};

    bpc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (s_mul_a),
        .i_b   (s_mul_b),
        .i_ctl (s_mul_ctl),
        .o_p   (s_mres)
    );

    bpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s_div_ctl),
        .i_dividend (s_div_a),
        .i_divisor  (s_div_d),
        .o_done     (s_div_done),
        .o_quot     (s_quot)
    );

    // State register and the stored b5
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_b5    <= '0;
        end else begin
            r_state <= n_state;
            r_b5    <= n_b5;
        end
    end

    // Scratch registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_raw <= n_raw;
        r_x1  <= n_x1;
        r_x2  <= n_x2;
        r_a   <= n_a;
        r_b6  <= n_b6;
        r_sq  <= n_sq;
        r_t   <= n_t;
        r_u   <= n_u;
        r_b3  <= n_b3;
        r_b4  <= n_b4;
        r_p   <= n_p;
        r_big <= n_big;
        r_val <= n_val;
        r_err <= n_err;
    end

    // Sequencer: each state drives the shared adder, multiplier and divider as its step needs
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_raw   = r_raw;
        n_b5    = r_b5;
        n_x1    = r_x1;
        n_x2    = r_x2;
        n_a     = r_a;
        n_b6    = r_b6;
        n_sq    = r_sq;
        n_t     = r_t;
        n_u     = r_u;
        n_b3    = r_b3;
        n_b4    = r_b4;
        n_p     = r_p;
        n_big   = r_big;
        n_val   = r_val;
        n_err   = r_err;

        s_add_a   = '0;
        s_add_b   = '0;
        s_add_cin = 1'b0;
        s_mul_a   = '0;
        s_mul_b   = '0;
        s_mul_ctl = '{sh: '0, arith: 1'b1};
        s_div_ctl = '{start: 1'b0, is_signed: 1'b0};
        s_div_a   = '0;
        s_div_d   = '0;

        unique case (r_state)
            S_IDLE: begin
                // Accept an item and pick the formula
                if (i_in.valid) begin
                    n_cmd   = i_in.command;
                    n_raw   = i_in.raw_value;
                    n_err   = 1'b0;
                    n_state = (i_in.command == CMD_PRES) ? S_P_B6 : S_T_MUL;
                end
            end

            // ---- temperature ----
            S_T_MUL: begin
                s_add_a   = {{(DATA_W-RAW_W){1'b0}}, r_raw};
                s_add_b   = ~s_ac6;
                s_add_cin = 1'b1;
                s_mul_a   = s_sum;
                s_mul_b   = s_ac5;
                s_mul_ctl = '{sh: SHIFT_W'(15), arith: 1'b1};
                n_state   = S_T_DEN;
            end
            S_T_DEN: begin
                s_add_a = s_mres;
                s_add_b = s_md;
                n_x1    = s_mres;
                n_a     = s_sum;
                n_state = S_T_CHK;
            end
            S_T_CHK: begin
                // Flag a zero divisor, else start the signed division
                if (r_a == '0) begin
                    n_val   = '0;
                    n_err   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    s_div_ctl = '{start: 1'b1, is_signed: 1'b1};
                    s_div_a   = s_mc << 11;
                    s_div_d   = r_a;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                // Wait for the quotient, then resume the formula in progress
                if (s_div_done) begin
                    if (r_cmd == CMD_TEMP) begin
                        n_x2    = s_quot;
                        n_state = S_T_B5;
                    end else begin
                        n_p     = r_big ? {s_quot[DATA_W-2:0], 1'b0} : s_quot;
                        n_state = S_P_SQP;
                    end
                end
            end
            S_T_B5: begin
                s_add_a = r_x1;
                s_add_b = r_x2;
                n_b5    = s_sum;
                n_state = S_T_RES;
            end
            S_T_RES: begin
                s_add_a = r_b5;
                s_add_b = C_T_ROUND;
                n_val   = f_asr(s_sum, SHIFT_W'(4));
                n_state = S_OUT;
            end

            // ---- pressure: b6 and its square ----
            S_P_B6: begin
                s_add_a   = r_b5;
                s_add_b   = ~C_B6_OFS;
                s_add_cin = 1'b1;
                n_b6      = s_sum;
                n_state   = S_P_SQ;
            end
            S_P_SQ: begin
                s_mul_a   = r_b6;
                s_mul_b   = r_b6;
                s_mul_ctl = '{sh: SHIFT_W'(12), arith: 1'b1};
                n_state   = S_P_AC2;
            end
            S_P_AC2: begin
                n_sq      = s_mres;
                s_mul_a   = s_ac2;
                s_mul_b   = r_b6;
                s_mul_ctl = '{sh: SHIFT_W'(11), arith: 1'b1};
                n_state   = S_P_B2;
            end
            S_P_B2: begin
                n_x2      = s_mres;
                s_mul_a   = s_b2;
                s_mul_b   = r_sq;
                s_mul_ctl = '{sh: SHIFT_W'(11), arith: 1'b1};
                n_state   = S_P_AC3;
            end
            S_P_AC3: begin
                n_x1      = s_mres;
                s_mul_a   = s_ac3;
                s_mul_b   = r_b6;
                s_mul_ctl = '{sh: SHIFT_W'(13), arith: 1'b1};
                n_state   = S_P_B1;
            end
            S_P_B1: begin
                n_t       = s_mres;
                s_mul_a   = s_b1;
                s_mul_b   = r_sq;
                s_mul_ctl = '{sh: SHIFT_W'(16), arith: 1'b1};
                n_state   = S_P_B3A;
            end

            // ---- pressure: b3 ----
            S_P_B3A: begin
                n_u     = s_mres;
                s_add_a = s_ac1 << 2;
                s_add_b = r_x1;
                n_a     = s_sum;
                n_state = S_P_B3B;
            end
            S_P_B3B: begin
                s_add_a = r_a;
                s_add_b = r_x2;
                n_a     = s_sum;
                n_state = S_P_B3C;
            end
            S_P_B3C: begin
                s_add_a = r_a << r_oss;
                s_add_b = C_B3_ROUND;
                n_a     = s_sum;
                n_state = S_P_B3D;
            end
            S_P_B3D: begin
                // Divide by four, truncating toward zero
                s_add_a = r_a;
                s_add_b = r_a[DATA_W-1] ? C_B3_TRUNC : '0;
                n_b3    = f_asr(s_sum, SHIFT_W'(2));
                n_state = S_P_X3A;
            end

            // ---- pressure: x3 and b4 ----
            S_P_X3A: begin
                s_add_a = r_t;
                s_add_b = r_u;
                n_a     = s_sum;
                n_state = S_P_X3B;
            end
            S_P_X3B: begin
                s_add_a = r_a;
                s_add_b = C_X3_ROUND;
                n_a     = f_asr(s_sum, SHIFT_W'(2));
                n_state = S_P_B4;
            end
            S_P_B4: begin
                s_add_a   = r_a;
                s_add_b   = C_B4_OFS;
                s_mul_a   = s_ac4;
                s_mul_b   = s_sum;
                s_mul_ctl = '{sh: SHIFT_W'(15), arith: 1'b0};
                n_state   = S_P_B7A;
            end

            // ---- pressure: b7 and the division ----
            S_P_B7A: begin
                n_b4      = s_mres;
                s_add_a   = {{(DATA_W-RAW_W){1'b0}}, r_raw};
                s_add_b   = ~r_b3;
                s_add_cin = 1'b1;
                n_a       = s_sum;
                n_state   = S_P_B7B;
            end
            S_P_B7B: begin
                if (r_b4 == '0) begin
                    n_val   = '0;
                    n_err   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    s_mul_a   = r_a;
                    s_mul_b   = C_B7_SCALE >> r_oss;
                    s_mul_ctl = '{sh: '0, arith: 1'b0};
                    n_state   = S_P_DIV;
                end
            end
            S_P_DIV: begin
                // Double before dividing unless the top bit is set
                n_big     = (s_mres >= C_B7_HALF);
                s_div_ctl = '{start: 1'b1, is_signed: 1'b0};
                s_div_a   = (s_mres >= C_B7_HALF) ? s_mres : {s_mres[DATA_W-2:0], 1'b0};
                s_div_d   = r_b4;
                n_state   = S_DIV;
            end

            // ---- pressure: final correction ----
            S_P_SQP: begin
                s_mul_a   = f_asr(r_p, SHIFT_W'(8));
                s_mul_b   = f_asr(r_p, SHIFT_W'(8));
                s_mul_ctl = '{sh: '0, arith: 1'b1};
                n_state   = S_P_X1;
            end
            S_P_X1: begin
                s_mul_a   = s_mres;
                s_mul_b   = C_P_SQ_K;
                s_mul_ctl = '{sh: SHIFT_W'(16), arith: 1'b1};
                n_state   = S_P_X2;
            end
            S_P_X2: begin
                n_x1      = s_mres;
                s_mul_a   = C_P_LIN_K;
                s_mul_b   = r_p;
                s_mul_ctl = '{sh: SHIFT_W'(16), arith: 1'b1};
                n_state   = S_P_SUM;
            end
            S_P_SUM: begin
                s_add_a = r_x1;
                s_add_b = s_mres;
                n_a     = s_sum;
                n_state = S_P_CORR;
            end
            S_P_CORR: begin
                s_add_a = r_a;
                s_add_b = C_P_OFS;
                n_a     = f_asr(s_sum, SHIFT_W'(4));
                n_state = S_P_FIN;
            end
            S_P_FIN: begin
                s_add_a = r_p;
                s_add_b = r_a;
                n_val   = s_sum;
                n_state = S_OUT;
            end

            S_OUT: begin
                // Hand the result over once the output register is free
                if (s_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_out_load = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    // Output register valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (s_out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_okind  <= r_cmd;
            r_ovalue <= r_val;
            r_oerr   <= r_err;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.kind      = r_okind;
    assign o_out.value     = $signed(r_ovalue);
    assign o_out.div_error = r_oerr;

endmodule

[rtl/bpc_checker.sv]
// Port-level checks on the compensation block, bound to its top level.
module bpc_checker
    import bpc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_kind,
    input logic [DATA_W-1:0] i_out_value,
    input logic              i_out_div_error
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_value) && $stable(i_out_kind) && $stable(i_out_div_error))
        else $error("result item changed while stalled");

    // A divisor error always reports a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_div_error |-> i_out_value == '0)
        else $error("division error with nonzero value");

    // An accepted item keeps the block busy for the next cycles
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("ready again too soon after an item");

    // No result appears right after an accept into an empty output
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result item appeared without processing");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_kind      (o_out.kind),
    .i_out_value     (o_out.value),
    .i_out_div_error (o_out.div_error)
);

[sim/bpc_compensation_checker.sv]
// Checker for the barometric compensation block: predicts each result item and compares it.
module bpc_compensation_checker
    import bpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bpc_in_if                     i_in,
    bpc_out_if                    i_res,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] value;
        logic              div_error;
    } t_reading_result;

    // Shadow copy of the calibration registers and of b5
    logic [CFG_DATA_W-1:0] cal_ac123;
    logic [CFG_DATA_W-1:0] cal_ac456;
    logic [31:0]           cal_b12;
    logic [31:0]           cal_mcmd;
    logic [OSS_W-1:0]      cal_oss;
    logic [DATA_W-1:0]     comp_b5;

    t_reading_result result_q[$];
    t_reading_result want;
    t_reading_result got;
    int              fail_count;

    assign o_fail_count  = fail_count;
    assign o_outstanding = result_q.size();

    // Arithmetic shift right of a 32-bit pattern
    function automatic logic [DATA_W-1:0] sra(input logic [DATA_W-1:0] v, input int n);
        return DATA_W'($signed(v) >>> n);
    endfunction

    function automatic logic [DATA_W-1:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Signed division truncating toward zero; most negative / -1 wraps
    function automatic logic [DATA_W-1:0] div_trunc(input logic [DATA_W-1:0] num,
                                                     input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] quo;
        mag_n = num[DATA_W-1] ? -num : num;
        mag_d = den[DATA_W-1] ? -den : den;
        quo   = mag_n / mag_d;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    // Compensate one raw reading; a good temperature item updates b5
    task automatic compensate(input logic cmd, input logic [RAW_W-1:0] raw,
                              output t_reading_result res);
        logic [DATA_W-1:0] raw32, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [DATA_W-1:0] x1, x2, x3, den, b3, b4, b6, b7, sq, p;
        logic [1:0]        sh;
        raw32 = {16'd0, raw};
        res.kind      = cmd;
        res.value     = '0;
        res.div_error = 1'b0;
        if (cmd == CMD_TEMP) begin
            ac5 = {16'd0, cal_ac456[31:16]};
            ac6 = {16'd0, cal_ac456[47:32]};
            mc  = sext16(cal_mcmd[15:0]);
            md  = sext16(cal_mcmd[31:16]);
            x1  = sra((raw32 - ac6) * ac5, 15);
            den = x1 + md;
            if (den == '0) begin
                res.div_error = 1'b1;
            end else begin
                x2        = div_trunc(mc << 11, den);
                comp_b5   = x1 + x2;
                res.value = sra(comp_b5 + 32'd8, 4);
            end
        end else begin
            sh  = cal_oss;
            ac1 = sext16(cal_ac123[15:0]);
            ac2 = sext16(cal_ac123[31:16]);
            ac3 = sext16(cal_ac123[47:32]);
            ac4 = {16'd0, cal_ac456[15:0]};
            b1  = sext16(cal_b12[15:0]);
            b2  = sext16(cal_b12[31:16]);
            b6  = comp_b5 - 32'd4000;
            sq  = sra(b6 * b6, 12);
            x1  = sra(b2 * sq, 11);
            x2  = sra(ac2 * b6, 11);
            b3  = div_trunc(((ac1 * 32'd4 + x1 + x2) << sh) + 32'd2, 32'd4);
            x1  = sra(ac3 * b6, 13);
            x2  = sra(b1 * sq, 16);
            x3  = sra(x1 + x2 + 32'd2, 2);
            b4  = (ac4 * (x3 + 32'd32768)) >> 15;
            if (b4 == '0) begin
                res.div_error = 1'b1;
            end else begin
                b7 = (raw32 - b3) * (32'd50000 >> sh);
                if (b7 < 32'h8000_0000) begin
                    p = (b7 * 32'd2) / b4;
                end else begin
                    p = (b7 / b4) * 32'd2;
                end
                x1 = sra(p, 8);
                x1 = x1 * x1;
                x1 = sra(x1 * 32'd3038, 16);
                x2 = sra((-32'd7357) * p, 16);
                res.value = p + sra(x1 + x2 + 32'd3791, 4);
            end
        end
    endtask

    // Track register writes, predict accepted readings, compare accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_ac123  = '0;
            cal_ac456  = '0;
            cal_b12    = '0;
            cal_mcmd   = '0;
            cal_oss    = '0;
            comp_b5    = '0;
            fail_count = 0;
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AC123: cal_ac123 = i_cfg_data;
                    CFG_AC456: cal_ac456 = i_cfg_data;
                    CFG_B12:   cal_b12   = i_cfg_data[31:0];
                    CFG_MCMD:  cal_mcmd  = i_cfg_data[31:0];
                    CFG_OSS:   cal_oss   = i_cfg_data[OSS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                compensate(i_in.command, i_in.raw_value, want);
                result_q.push_back(want);
            end
            if (i_res.valid && i_res.ready) begin
                got.kind      = i_res.kind;
                got.value     = i_res.value;
                got.div_error = i_res.div_error;
                if (result_q.size() == 0) begin
                    $error("result item with no reading outstanding: kind %0d value %0d",
                           got.kind, $signed(got.value));
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.value !== want.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(want.value), $signed(got.value));
                        fail_count++;
                    end
                    if (got.div_error !== want.div_error) begin
                        $error("div_error: expected %0d, got %0d",
                               want.div_error, got.div_error);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[sim/testbench.sv]
// Top of the compensation testbench: clock, reset, stimulus, result sink and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    // Typical calibration set, fields packed from the low bits
    localparam logic [CFG_DATA_W-1:0] AC123_TYP = {16'(-14383), 16'(-72), 16'd408};
    localparam logic [CFG_DATA_W-1:0] AC456_TYP = {16'd23153, 16'd32757, 16'd32741};
    localparam logic [CFG_DATA_W-1:0] B12_TYP   = {16'd0, 16'd4, 16'd6190};
    localparam logic [CFG_DATA_W-1:0] MCMD_TYP  = {16'd0, 16'd2868, 16'(-8711)};
    localparam logic [CFG_DATA_W-1:0] ALL_ONES  = '1;
    localparam int RANDOM_BLOCKS   = 21;
    localparam int ITEMS_PER_BLOCK = 34;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    src_idle_pct = 35;
    int                    snk_idle_pct = 69;

    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();

    baro_pressure_temp_compensation u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    bpc_compensation_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in          (in_ch),
        .i_res         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("baro_pressure_temp_compensation: mismatch");
        $finish;
    end

    // Offer one reading, idling first at random; return once it is accepted
    task automatic send_reading(input logic cmd, input logic [RAW_W-1:0] raw);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.raw_value <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_cal(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic write_all_cal(input logic [CFG_DATA_W-1:0] ac123,
                                 input logic [CFG_DATA_W-1:0] ac456,
                                 input logic [CFG_DATA_W-1:0] b12,
                                 input logic [CFG_DATA_W-1:0] mcmd,
                                 input logic [OSS_W-1:0]      oss_val);
        write_cal(CFG_AC123, ac123);
        write_cal(CFG_AC456, ac456);
        write_cal(CFG_B12, b12);
        write_cal(CFG_MCMD, mcmd);
        write_cal(CFG_OSS, CFG_DATA_W'(oss_val));
    endtask

    // Nudge each 16-bit field of a typical word by a small random amount
    function automatic logic [CFG_DATA_W-1:0] jitter(input logic [CFG_DATA_W-1:0] w);
        logic [CFG_DATA_W-1:0] r;
        r = w;
        for (int k = 0; k < 3; k++) begin
            r[16*k +: 16] = w[16*k +: 16] + 16'($urandom_range(512)) - 16'd256;
        end
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] zero_or_ones();
        return $urandom_range(1) ? ALL_ONES : '0;
    endfunction

    // Load one calibration setting for a random block
    task automatic program_random_cal(input int style);
        case (style)
            0: write_all_cal(CFG_DATA_W'({$urandom, $urandom}), CFG_DATA_W'({$urandom, $urandom}),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             OSS_W'($urandom_range(3)));
            1: write_all_cal(jitter(AC123_TYP), jitter(AC456_TYP), jitter(B12_TYP) & 48'hFFFF_FFFF,
                             jitter(MCMD_TYP) & 48'hFFFF_FFFF, OSS_W'($urandom_range(3)));
            2: write_all_cal(zero_or_ones(), zero_or_ones(), zero_or_ones() & 48'hFFFF_FFFF,
                             zero_or_ones() & 48'hFFFF_FFFF, $urandom_range(1) ? 2'd3 : 2'd0);
            default: write_all_cal(AC123_TYP, AC456_TYP, B12_TYP, MCMD_TYP,
                                   OSS_W'($urandom_range(3)));
        endcase
    endtask

    initial begin
        logic             cmd;
        logic [RAW_W-1:0] raw;

        // Drive every input known from time zero while reset is held low
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_TEMP;
        in_ch.raw_value = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration: pressure before any temperature, both divisors zero
        send_reading(CMD_PRES, 16'h0000);
        send_reading(CMD_TEMP, 16'hFFFF);
        wait_for_results();

        // Typical calibration, raw extremes
        write_all_cal(AC123_TYP, AC456_TYP, B12_TYP, MCMD_TYP, 2'd0);
        send_reading(CMD_TEMP, 16'd27898);
        send_reading(CMD_PRES, 16'd23843);
        send_reading(CMD_TEMP, 16'h0000);
        send_reading(CMD_PRES, 16'hFFFF);
        send_reading(CMD_TEMP, 16'hFFFF);
        send_reading(CMD_PRES, 16'h0000);
        wait_for_results();
        write_cal(CFG_OSS, CFG_DATA_W'(2'd3));
        send_reading(CMD_PRES, 16'h8000);
        send_reading(CMD_TEMP, 16'h7FFF);
        send_reading(CMD_PRES, 16'h7FFF);
        wait_for_results();

        // Temperature divisor zero with live calibration; b5 must hold
        write_cal(CFG_AC456, {16'd1000, 16'd32768, 16'd32741});
        write_cal(CFG_MCMD, {16'd0, 16'(-500), 16'(-8711)});
        send_reading(CMD_TEMP, 16'd1500);
        send_reading(CMD_PRES, 16'd40000);
        send_reading(CMD_TEMP, 16'd2000);
        wait_for_results();

        // Pressure divisor zero through ac4
        write_cal(CFG_AC456, {16'd23153, 16'd32757, 16'd0});
        write_cal(CFG_MCMD, MCMD_TYP);
        send_reading(CMD_TEMP, 16'd27898);
        send_reading(CMD_PRES, 16'd23843);
        wait_for_results();

        // Every calibration bit set
        write_all_cal(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 2'd3);
        send_reading(CMD_TEMP, 16'hFFFF);
        send_reading(CMD_PRES, 16'h0000);
        send_reading(CMD_TEMP, 16'h0000);
        send_reading(CMD_PRES, 16'hFFFF);

        // Random blocks, each under its own calibration; mostly temperature/pressure pairs
        cmd = CMD_PRES;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            if (blk == RANDOM_BLOCKS / 3) begin
                src_idle_pct = 69;
                snk_idle_pct = 35;
            end else if (blk == 2 * RANDOM_BLOCKS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            wait_for_results();
            program_random_cal(blk % 4);
            repeat (ITEMS_PER_BLOCK) begin
                if (cmd == CMD_TEMP) begin
                    cmd = ($urandom_range(99) < 80) ? CMD_PRES : CMD_TEMP;
                end else begin
                    cmd = ($urandom_range(99) < 70) ? CMD_TEMP : CMD_PRES;
                end
                if ($urandom_range(3) == 0) begin
                    raw = (cmd == CMD_TEMP) ? RAW_W'($urandom_range(36000, 20000))
                                            : RAW_W'($urandom_range(40000, 15000));
                end else begin
                    raw = RAW_W'($urandom_range(16'hFFFF));
                end
                send_reading(cmd, raw);
            end
        end

        // Drain, then allow for any stray result item
        wait_for_results();
        repeat (80) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("baro_pressure_temp_compensation: match");
        end else begin
            $display("baro_pressure_temp_compensation: mismatch");
        end
        $finish;
    end

endmodule
